[rtl/sbmd_pkg.sv]
// ----------------------------------------------------------------------------
// sbmd_pkg
// Shared types and constants of the SSD block match disparity unit.
// ----------------------------------------------------------------------------
package sbmd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IMAGE_COLS     = 3'd0;
    localparam logic [2:0] CFG_IMAGE_ROWS     = 3'd1;
    localparam logic [2:0] CFG_SEARCH_RANGE   = 3'd2;
    localparam logic [2:0] CFG_HALF_WINDOW    = 3'd3;
    localparam logic [2:0] CFG_NO_MATCH_LIMIT = 3'd4;

    // Register reset values.
    localparam logic [10:0] RST_IMAGE_COLS     = 11'd640;
    localparam logic [10:0] RST_IMAGE_ROWS     = 11'd480;
    localparam logic [6:0]  RST_SEARCH_RANGE   = 7'd30;
    localparam logic [2:0]  RST_HALF_WINDOW    = 3'd3;
    localparam logic [23:0] RST_NO_MATCH_LIMIT = 24'd10000;

    // Controls broadcast by the sequencer to every cell.
    typedef struct packed {
        logic clr;      // zero the accumulated cost
        logic acc_en;   // add the squared difference of this cycle
        logic shift;    // take the cost of the upper neighbor
    } t_cell_ctrl;

    // Tag that travels with each pixel pair down the chain.
    typedef struct packed {
        logic valid;    // the pair holds read data
        logic en;       // the right pixel lies inside the right window
        logic last;     // final pair of the window sweep
    } t_tag;

endpackage

[rtl/sbmd_line_store.sv]
// ----------------------------------------------------------------------------
// sbmd_line_store
// Line buffer of the most recent image rows, one write and one registered read.
// ----------------------------------------------------------------------------
module sbmd_line_store #(
    parameter  int PIX_W = 8,
    parameter  int LINES = 15,
    parameter  int COLS  = 1024,
    localparam int SL_W  = $clog2(LINES),
    localparam int CL_W  = $clog2(COLS)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [SL_W-1:0]  i_wr_slot,
    input  logic [CL_W-1:0]  i_wr_col,
    input  logic [PIX_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [SL_W-1:0]  i_rd_slot,
    input  logic [CL_W-1:0]  i_rd_col,
    output logic [PIX_W-1:0] o_rd_data
);

    logic [PIX_W-1:0] r_mem [LINES][COLS];
    logic [PIX_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot][i_wr_col] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot][i_rd_col];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/sbmd_cell.sv]
// ----------------------------------------------------------------------------
// sbmd_cell
// One disparity cell: shifts pixel pairs down the chain and accumulates the
// squared differences of its candidate window.
// ----------------------------------------------------------------------------
module sbmd_cell #(
    parameter int PIX_W  = 8,
    parameter int COST_W = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbmd_pkg::t_cell_ctrl i_ctrl,
    input  logic [PIX_W-1:0]     i_left,
    input  logic [PIX_W-1:0]     i_right,
    input  sbmd_pkg::t_tag       i_tag,
    input  logic [COST_W-1:0]    i_cost,
    input  logic [PIX_W-1:0]     i_bc_right,
    output logic [PIX_W-1:0]     o_left,
    output logic [PIX_W-1:0]     o_right,
    output sbmd_pkg::t_tag       o_tag,
    output logic [COST_W-1:0]    o_cost
);
    import sbmd_pkg::*;

    logic [PIX_W-1:0]   r_left;
    logic [PIX_W-1:0]   r_right;
    t_tag               r_tag;
    logic [COST_W-1:0]  r_cost;
    logic [PIX_W-1:0]   w_diff;
    logic [2*PIX_W-1:0] w_sq;

    // Absolute difference against the broadcast right pixel, then squared.
    assign w_diff = (r_left > i_bc_right) ? (r_left - i_bc_right) : (i_bc_right - r_left);
    assign w_sq   = w_diff * w_diff;

    // Pixel pairs move one cell down every cycle.
    always_ff @(posedge i_clk) begin
        r_left  <= i_left;
        r_right <= i_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // Cost accumulator, also a shift line for the minimum scan.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_cost <= '0;
        end else if (i_ctrl.shift) begin
            r_cost <= i_cost;
        end else if (i_ctrl.acc_en) begin
            r_cost <= r_cost + COST_W'(w_sq);
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_tag   = r_tag;
    assign o_cost  = r_cost;

endmodule

[rtl/ssd_block_match_disparity_unit.sv]
// ----------------------------------------------------------------------------
// ssd_block_match_disparity_unit
// SSD stereo block matching over a raster stream with a chain of disparity
// cells fed from two line stores.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction content
// s_axis    in         left and right pixel of one raster position
// m_axis    out        disparity, row, column; tlast on the frame's last one
// cfg       in         register write: index and data
//
// A position without a result is written to the line stores and the block stays
// idle. A position with a result passes through the accept, the window reads,
// the drain of the cell chain, the minimum scan and the load of the output
// register in that order; the single read port of each line store sets the read phase.
// Reset loads the register reset values and clears the raster counters, the
// output valid flag and the control state; line stores hold no reset value. A
// stalled result waits in the output register while the next pair is accepted.
// ----------------------------------------------------------------------------
module ssd_block_match_disparity_unit #(
    parameter  int MAX_COLS     = 1024,
    parameter  int MAX_HALF_WIN = 7,
    parameter  int MAX_SEARCH   = 64,
    parameter  int PIXEL_BITS   = 8,
    localparam int IN_W         = ((2 * PIXEL_BITS + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,   // left_pixel, right_pixel
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [31:0]     m_axis_tdata,   // disparity, out_row, out_col
    output logic            m_axis_tlast,   // frame_last
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [23:0]     i_cfg_data
);
    import sbmd_pkg::*;

    localparam int LINES  = 2 * MAX_HALF_WIN + 1;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int SL_W   = $clog2(LINES);
    localparam int DC_W   = $clog2(MAX_COLS + 1);
    localparam int SC_W   = $clog2(MAX_SEARCH + 1);
    localparam int HC_W   = $clog2(MAX_HALF_WIN + 1);
    localparam int CXW    = (DC_W > 11) ? DC_W : 11;
    localparam int SXW    = (SC_W > 7) ? SC_W : 7;
    localparam int HXW    = (HC_W > 3) ? HC_W : 3;
    localparam int VW     = DC_W + SC_W + 2;
    localparam int K_W    = $clog2(2 * MAX_HALF_WIN + 1);
    localparam int J_W    = $clog2(2 * MAX_HALF_WIN + MAX_SEARCH);
    localparam int I_W    = $clog2(MAX_SEARCH);
    localparam int COST_W = 2 * PIXEL_BITS + $clog2(LINES * LINES);
    localparam int CMP_W  = (COST_W > 24) ? COST_W : 24;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [10:0] r_cfg_cols, r_cfg_rows;
    logic [6:0]  r_cfg_search;
    logic [2:0]  r_cfg_half;
    logic [23:0] r_cfg_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols   <= RST_IMAGE_COLS;
            r_cfg_rows   <= RST_IMAGE_ROWS;
            r_cfg_search <= RST_SEARCH_RANGE;
            r_cfg_half   <= RST_HALF_WINDOW;
            r_cfg_limit  <= RST_NO_MATCH_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_COLS:     r_cfg_cols   <= i_cfg_data[10:0];
                CFG_IMAGE_ROWS:     r_cfg_rows   <= i_cfg_data[10:0];
                CFG_SEARCH_RANGE:   r_cfg_search <= i_cfg_data[6:0];
                CFG_HALF_WINDOW:    r_cfg_half   <= i_cfg_data[2:0];
                CFG_NO_MATCH_LIMIT: r_cfg_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped register values.
    logic [CXW-1:0]  w_cols_x, w_rows_x;
    logic [SXW-1:0]  w_s_x;
    logic [HXW-1:0]  w_h_x;
    logic [DC_W-1:0] w_cols, w_rows;
    logic [SC_W-1:0] w_s;
    logic [HC_W-1:0] w_h;

    assign w_cols_x = CXW'(r_cfg_cols);
    assign w_rows_x = CXW'(r_cfg_rows);
    assign w_s_x    = SXW'(r_cfg_search);
    assign w_h_x    = HXW'(r_cfg_half);
    assign w_cols = (w_cols_x == '0) ? DC_W'(1) :
                    (w_cols_x > CXW'(MAX_COLS)) ? DC_W'(MAX_COLS) : DC_W'(w_cols_x);
    assign w_rows = (w_rows_x == '0) ? DC_W'(1) :
                    (w_rows_x > CXW'(MAX_COLS)) ? DC_W'(MAX_COLS) : DC_W'(w_rows_x);
    assign w_s    = (w_s_x == '0) ? SC_W'(1) :
                    (w_s_x > SXW'(MAX_SEARCH)) ? SC_W'(MAX_SEARCH) : SC_W'(w_s_x);
    assign w_h    = (w_h_x > HXW'(MAX_HALF_WIN)) ? HC_W'(MAX_HALF_WIN) : HC_W'(w_h_x);

    // Raster position of the next input pixel and its line store slot.
    logic [COL_W-1:0] r_row, r_col;
    logic [SL_W-1:0]  r_slot;
    logic             w_in_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (w_in_acc) begin
            if (DC_W'(r_col) + DC_W'(1) >= w_cols) begin
                r_col <= '0;
                if (DC_W'(r_row) + DC_W'(1) >= w_rows) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + COL_W'(1);
                    r_slot <= (r_slot == SL_W'(LINES - 1)) ? '0 : r_slot + SL_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Position check and window geometry of the accepted pixel.
    logic [VW-1:0] v_row, v_col, v_rows, v_cols, v_h, v_h2, v_s;
    logic [VW-1:0] w_r0, w_c0, w_xs, w_slot_x;
    logic          w_pos_ok, w_last_pos;
    logic [SL_W-1:0] w_slot_start;

    assign v_row  = VW'(r_row);
    assign v_col  = VW'(r_col);
    assign v_rows = VW'(w_rows);
    assign v_cols = VW'(w_cols);
    assign v_h    = VW'(w_h);
    assign v_h2   = v_h + v_h;
    assign v_s    = VW'(w_s);

    assign w_pos_ok   = (v_row < v_rows) && (v_row >= v_h2) &&
                        (v_col + VW'(1) >= v_h2 + v_s) && (v_col + VW'(1) < v_cols);
    assign w_last_pos = (v_row + VW'(1) == v_rows) && (v_col + VW'(2) == v_cols);
    assign w_r0       = v_row - v_h;
    assign w_c0       = v_col + VW'(1) - v_h - v_s;
    assign w_xs       = w_c0 - v_h;
    assign w_slot_x   = VW'(r_slot);
    assign w_slot_start = (w_slot_x >= v_h2) ? SL_W'(w_slot_x - v_h2) :
                                               SL_W'(w_slot_x + VW'(LINES) - v_h2);

    // Line stores.
    logic [PIXEL_BITS-1:0] w_in_left, w_in_right, w_rd_left, w_rd_right;
    logic [SL_W-1:0]       r_rd_slot;
    logic [COL_W-1:0]      r_xs, w_rd_col;
    logic [K_W-1:0]        r_k, r_h2;
    logic [J_W-1:0]        r_j, r_jmax;
    logic                  w_rd_en;

    assign w_in_left  = s_axis_tdata[PIXEL_BITS-1:0];
    assign w_in_right = s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign w_rd_en    = (r_state == ST_READ);
    assign w_rd_col   = r_xs + COL_W'(r_j);

    sbmd_line_store #(.PIX_W(PIXEL_BITS), .LINES(LINES), .COLS(MAX_COLS)) u_left_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc),
        .i_wr_slot (r_slot),
        .i_wr_col  (r_col),
        .i_wr_data (w_in_left),
        .i_rd_en   (w_rd_en),
        .i_rd_slot (r_rd_slot),
        .i_rd_col  (w_rd_col),
        .o_rd_data (w_rd_left)
    );

    sbmd_line_store #(.PIX_W(PIXEL_BITS), .LINES(LINES), .COLS(MAX_COLS)) u_right_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc),
        .i_wr_slot (r_slot),
        .i_wr_col  (r_col),
        .i_wr_data (w_in_right),
        .i_rd_en   (w_rd_en),
        .i_rd_slot (r_rd_slot),
        .i_rd_col  (w_rd_col),
        .o_rd_data (w_rd_right)
    );

    // Tag registered alongside the read data, so that the two arrive together.
    t_tag r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag.valid <= w_rd_en;
            r_rd_tag.en    <= (J_W'(r_h2) >= r_j);
            r_rd_tag.last  <= (r_k == r_h2) && (r_j == r_jmax);
        end
    end

    // Chain of disparity cells; the pair stream enters at the top cell.
    logic [PIXEL_BITS-1:0] w_left [MAX_SEARCH+1];
    logic [PIXEL_BITS-1:0] w_right[MAX_SEARCH+1];
    t_tag                  w_tag  [MAX_SEARCH+1];
    logic [COST_W-1:0]     w_cost [MAX_SEARCH+1];
    t_cell_ctrl            w_ctrl;
    logic                  w_start;

    assign w_left[MAX_SEARCH]  = w_rd_left;
    assign w_right[MAX_SEARCH] = w_rd_right;
    assign w_tag[MAX_SEARCH]   = r_rd_tag;
    assign w_cost[MAX_SEARCH]  = '0;

    assign w_start       = w_in_acc && w_pos_ok;
    assign w_ctrl.clr    = w_start;
    assign w_ctrl.acc_en = w_tag[0].valid && w_tag[0].en;
    assign w_ctrl.shift  = (r_state == ST_SCAN);

    for (genvar gi = 0; gi < MAX_SEARCH; gi++) begin : g_cell
        sbmd_cell #(.PIX_W(PIXEL_BITS), .COST_W(COST_W)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_left     (w_left[gi+1]),
            .i_right    (w_right[gi+1]),
            .i_tag      (w_tag[gi+1]),
            .i_cost     (w_cost[gi+1]),
            .i_bc_right (w_right[0]),
            .o_left     (w_left[gi]),
            .o_right    (w_right[gi]),
            .o_tag      (w_tag[gi]),
            .o_cost     (w_cost[gi])
        );
    end

    // Sequencer state.
    logic [I_W-1:0]   r_idx, r_sm1, r_best_idx;
    logic [CMP_W-1:0] r_best;
    logic [9:0]       r_res_row, r_res_col;
    logic             r_res_last;
    logic             r_out_valid, w_out_load;

    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_start) n_state = ST_READ;
            ST_READ:  if ((r_k == r_h2) && (r_j == r_jmax)) n_state = ST_DRAIN;
            ST_DRAIN: if (w_tag[0].valid && w_tag[0].last) n_state = ST_SCAN;
            ST_SCAN:  if (r_idx == r_sm1) n_state = ST_DONE;
            ST_DONE:  if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window sweep counters and per-item geometry.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_k        <= '0;
            r_j        <= '0;
            r_rd_slot  <= w_slot_start;
            r_xs       <= COL_W'(w_xs);
            r_h2       <= K_W'(v_h2);
            r_jmax     <= J_W'(v_h2 + v_s - VW'(1));
            r_sm1      <= I_W'(v_s - VW'(1));
            r_res_row  <= 10'(w_r0);
            r_res_col  <= 10'(w_c0);
            r_res_last <= w_last_pos;
        end else if (r_state == ST_READ) begin
            if (r_j == r_jmax) begin
                r_j       <= '0;
                r_k       <= r_k + K_W'(1);
                r_rd_slot <= (r_rd_slot == SL_W'(LINES - 1)) ? '0 : r_rd_slot + SL_W'(1);
            end else begin
                r_j <= r_j + J_W'(1);
            end
        end
    end

    // Minimum scan over the costs shifted out of the bottom cell.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_idx      <= '0;
            r_best     <= CMP_W'(r_cfg_limit);
            r_best_idx <= '0;
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + I_W'(1);
            if (CMP_W'(w_cost[0]) < r_best) begin
                r_best     <= CMP_W'(w_cost[0]);
                r_best_idx <= r_idx;
            end
        end
    end

    // Output register.
    logic [5:0] r_out_disp;
    logic [9:0] r_out_row, r_out_col;
    logic       r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_disp <= 6'(r_best_idx);
            r_out_row  <= r_res_row;
            r_out_col  <= r_res_col;
            r_out_last <= r_res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_col, r_out_row, r_out_disp};
    assign m_axis_tlast  = r_out_last;

    // No pair may reach the bottom cell once the minimum scan has begun.
    a_scan_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !w_tag[0].valid)
        else $error("pixel pair reached the bottom cell during the scan");

    // A result is loaded only from the done state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("output loaded outside the done state");

    // The chosen disparity lies within the search range of the item.
    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_best_idx <= r_sm1))
        else $error("best disparity outside the search range");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the SSD block match disparity unit. Whole frames of stereo
// pixel pairs are streamed in. A line-store predictor computes the expected
// disparity of every valid position, and each output transaction is checked
// against it in order. The run covers random and shifted image content,
// small and extreme sizes, and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import sbmd_pkg::*;

    localparam int LINES      = 15;
    localparam int MAXC       = 1024;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN      = 1500;   // worst result latency with margin
    localparam int RAND_ITEMS = 480;

    typedef struct packed {
        logic [5:0] disp;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_disp_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // left_pixel, right_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // disparity, out_row, out_col
    logic        m_axis_tlast;   // frame_last
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    ssd_block_match_disparity_unit DUT (.*);

    // Predictor state: line stores, position counters and register copies.
    logic [7:0]   left_lines  [LINES][MAXC];
    logic [7:0]   right_lines [LINES][MAXC];
    int           row_cnt, col_cnt;
    logic [10:0]  reg_cols, reg_rows;
    logic [6:0]   reg_search;
    logic [2:0]   reg_half;
    logic [23:0]  reg_limit;
    t_disp_result disparity_q[$];

    int  idle_pct, stall_pct;
    int  n_items, n_results, n_errors, wdog;
    int  rand_items;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected disparity for the pair just accepted; advances the counters.
    function automatic void predict_disparity(logic [7:0] lp, logic [7:0] rp);
        int cols, rows, s, h, r0, c0, best_i;
        longint best, cost, d;
        t_disp_result res;
        cols = (reg_cols < 1) ? 1 : (reg_cols > MAXC) ? MAXC : int'(reg_cols);
        rows = (reg_rows < 1) ? 1 : (reg_rows > MAXC) ? MAXC : int'(reg_rows);
        s    = (reg_search < 1) ? 1 : (reg_search > 64) ? 64 : int'(reg_search);
        h    = int'(reg_half);
        if (col_cnt < MAXC) begin
            left_lines[row_cnt % LINES][col_cnt]  = lp;
            right_lines[row_cnt % LINES][col_cnt] = rp;
        end
        if (row_cnt < rows && row_cnt >= 2 * h && col_cnt >= 2 * h + s - 1 &&
            col_cnt < cols - 1) begin
            r0 = row_cnt - h;
            c0 = col_cnt - h - s + 1;
            best = reg_limit;
            best_i = 0;
            for (int i = 0; i < s; i++) begin
                cost = 0;
                for (int dr = -h; dr <= h; dr++)
                    for (int dc = -h; dc <= h; dc++) begin
                        d = longint'(left_lines[(r0 + dr) % LINES][c0 + i + dc]) -
                            longint'(right_lines[(r0 + dr) % LINES][c0 + dc]);
                        cost += d * d;
                    end
                if (cost < best) begin
                    best = cost;
                    best_i = i;
                end
            end
            res.disp = best_i[5:0];
            res.row  = r0[9:0];
            res.col  = c0[9:0];
            res.last = (row_cnt == rows - 1 && col_cnt == cols - 2);
            disparity_q.push_back(res);
        end
        col_cnt++;
        if (col_cnt >= cols) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= rows) row_cnt = 0;
        end
    endfunction

    // Sends one pixel pair; valid stays high across back-to-back transactions.
    task automatic send_pair(logic [7:0] lp, logic [7:0] rp);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rp, lp};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_disparity(lp, rp);
        n_items++;
    endtask

    // Waits until all results are in and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (disparity_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Writes all five registers on consecutive cycles.
    task automatic set_config(int cols, int rows, int s, int h, int lim);
        logic [2:0]  idx [5];
        logic [23:0] val [5];
        idx = '{CFG_IMAGE_COLS, CFG_IMAGE_ROWS, CFG_SEARCH_RANGE,
                CFG_HALF_WINDOW, CFG_NO_MATCH_LIMIT};
        val = '{cols[23:0], rows[23:0], s[23:0], h[23:0], lim[23:0]};
        wait_idle();
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        reg_cols   = cols[10:0];
        reg_rows   = rows[10:0];
        reg_search = s[6:0];
        reg_half   = h[2:0];
        reg_limit  = lim[23:0];
    endtask

    // Streams one frame. Shifted content copies the left row into the right
    // one at a fixed disparity, with a little noise.
    task automatic run_frame(int cols, int rows, int s, int h, int lim, bit shifted);
        int ec, er, shift;
        logic [7:0] base [MAXC];
        set_config(cols, rows, s, h, lim);
        ec = (cols[10:0] < 1) ? 1 : (cols[10:0] > MAXC) ? MAXC : cols[10:0];
        er = (rows[10:0] < 1) ? 1 : (rows[10:0] > MAXC) ? MAXC : rows[10:0];
        shift = $urandom_range((s > 64) ? 63 : (s < 1 ? 0 : s - 1));
        for (int r = 0; r < er; r++) begin
            for (int c = 0; c < ec; c++) base[c] = 8'($urandom_range(255));
            for (int c = 0; c < ec; c++) begin
                logic [7:0] rp;
                rp = (c + shift < ec) ? base[c + shift] : 8'($urandom_range(255));
                if (!shifted || $urandom_range(9) == 0) rp = 8'($urandom_range(255));
                send_pair(base[c], rp);
            end
        end
    endtask

    // Corner pixel values, zero limit, ties and the smallest frames.
    task automatic test_directed();
        run_frame(3, 1, 1, 0, 0, 0);
        run_frame(4, 1, 1, 0, 24'hFFFFFF, 0);
        set_config(4, 1, 1, 0, 1);
        send_pair(8'hFF, 8'h00);
        send_pair(8'h00, 8'hFF);
        send_pair(8'hFF, 8'hFF);
        send_pair(8'h00, 8'h00);
        set_config(5, 3, 2, 1, 24'hFFFFFF);
        for (int k = 0; k < 15; k++) send_pair(8'h80, 8'h80);
    endtask

    // Largest window over a full line store with the largest limit.
    task automatic test_max_window();
        run_frame(20, 15, 2, 7, 24'hFFFFFF, 1);
    endtask

    // Out-of-range register values; the widest row with the full search range.
    task automatic test_clamped_sizes();
        run_frame(2047, 0, 127, 0, 5, 1);
        run_frame(0, 2, 0, 0, 10000, 0);
    endtask

    // Random small frames across the four handshake pressure phases.
    task automatic test_random_frames();
        int h, s, lim, start;
        int idle_tab [4] = '{0, 65, 0, 34};
        int stall_tab[4] = '{0, 0, 65, 34};
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            start = n_items;
            while (n_items - start < RAND_ITEMS / 4) begin
                h = $urandom_range(3);
                s = $urandom_range(1, 12);
                case ($urandom_range(3))
                    0:       lim = 0;
                    1:       lim = 24'hFFFFFF;
                    default: lim = $urandom_range(20000);
                endcase
                run_frame(2 * h + s + $urandom_range(1, 10), 2 * h + $urandom_range(1, 4),
                          s, h, lim, $urandom_range(4) != 0);
            end
            rand_items += n_items - start;
        end
    endtask

    // Receiver stalls.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Compares each disparity transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_disp_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (disparity_q.size() == 0) begin
                $display("%0t: unexpected result disp=%0d row=%0d col=%0d last=%0b", $time,
                         m_axis_tdata[5:0], m_axis_tdata[15:6], m_axis_tdata[25:16],
                         m_axis_tlast);
                n_errors++;
            end else begin
                want = disparity_q.pop_front();
                if (m_axis_tdata[5:0] !== want.disp || m_axis_tdata[15:6] !== want.row ||
                    m_axis_tdata[25:16] !== want.col || m_axis_tlast !== want.last ||
                    m_axis_tdata[31:26] !== 6'd0) begin
                    $display("%0t: mismatch expected disp=%0d row=%0d col=%0d last=%0b",
                             $time, want.disp, want.row, want.col, want.last);
                    $display("%0t:          actual   disp=%0d row=%0d col=%0d last=%0b pad=%0h",
                             $time, m_axis_tdata[5:0], m_axis_tdata[15:6],
                             m_axis_tdata[25:16], m_axis_tlast, m_axis_tdata[31:26]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_IMAGE_COLS;
        i_cfg_data    = '0;
        idle_pct = 0; stall_pct = 0;
        n_items = 0; n_results = 0; n_errors = 0; wdog = 0; rand_items = 0;
        row_cnt = 0; col_cnt = 0;
        reg_cols = RST_IMAGE_COLS; reg_rows = RST_IMAGE_ROWS;
        reg_search = RST_SEARCH_RANGE; reg_half = RST_HALF_WINDOW;
        reg_limit = RST_NO_MATCH_LIMIT;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_max_window();
        test_clamped_sizes();
        test_random_frames();
        wait_idle();

        $display("Sent %0d pixel pairs (%0d in random frames), checked %0d disparities.",
                 n_items, rand_items, n_results);
        $display("Covered windows 1x1 to 15x15, search 1 to 64, clamped sizes and stalls.");
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
